[rtl/spq_pkg.sv]
// Shared types and codes for the sorted priority queue.
// No dependencies; imported by the controller, the datapath and the top level.

package spq_pkg;

    localparam int MODE_W = 2;
    localparam int ERR_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_PUSH   = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic commit;
        op_t  op;
        err_t err;
    } spq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic ins_req;
        logic rem_req;
        logic full;
        logic empty;
    } spq_status_t;

endpackage

[rtl/sorted_priority_queue.sv]
// Sorted priority queue, top level: ordered row of value/priority cells.
// The request is captured on acceptance; the result is registered on the commit step that
// follows (capture/compare, then shift/commit). A new request is accepted only in idle;
// a waiting result holds the commit step, so the next request waits in turn.
// Reset: rst_n asynchronous active low empties the queue; cell contents undefined.
// Depends on spq_pkg, spq_ctrl and spq_datapath.

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 16,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
    localparam int IN_W  = ((spq_pkg::MODE_W + VALUE_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8,
    localparam int OUT_W =
        ((VALUE_WIDTH + PRIORITY_WIDTH + 1 + CNT_W + spq_pkg::ERR_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // mode, item_value, item_priority (from bit 0 up), zero padded
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // front_value, front_priority, is_empty, entry_count, error_code (from bit 0 up)
    output logic [OUT_W-1:0] m_tdata
);
    import spq_pkg::*;

    spq_cmd_t    cmd;
    spq_status_t status;

    // sequencing: accept a request, then commit it once the result slot is free
    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // cells compare in parallel on capture and shift one place on commit
    spq_datapath #(
        .DEPTH (QUEUE_DEPTH),
        .VW    (VALUE_WIDTH),
        .PW    (PRIORITY_WIDTH),
        .CW    (CNT_W),
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata)
    );

endmodule

[rtl/spq_ctrl.sv]
// Controller for the sorted priority queue: handshake and sequencing FSM.
// Depends on spq_pkg.

module spq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  spq_pkg::spq_status_t status,
    output spq_pkg::spq_cmd_t    cmd
);
    import spq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        cmd.op      = OP_NONE;
        cmd.err     = ERR_OK;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC:
            begin
                cmd.commit = out_free;
                if (status.ins_req)
                begin
                    if (status.full)
                    begin
                        cmd.err = ERR_FULL;
                    end
                    else if (out_free)
                    begin
                        cmd.op = OP_INSERT;
                    end
                end
                else if (status.rem_req)
                begin
                    if (status.empty)
                    begin
                        cmd.err = ERR_EMPTY;
                    end
                    else if (out_free)
                    begin
                        cmd.op = OP_REMOVE;
                    end
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // hold the result until taken, load a new one on commit
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_tvalid_reg || m_tready))
        else $error("result committed over an untaken result");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted request did not advance to execute");

endmodule

[rtl/spq_datapath.sv]
// Datapath of the sorted priority queue: row of entry cells, compare flags,
// occupancy counter and result register. Depends on spq_pkg.

module spq_datapath #(
    parameter int DEPTH = 16,
    parameter int VW    = 32,
    parameter int PW    = 16,
    parameter int CW    = 5,
    parameter int IN_W  = 56,
    parameter int OUT_W = 56
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IN_W-1:0]      s_tdata,
    input  spq_pkg::spq_cmd_t    cmd,
    output spq_pkg::spq_status_t status,
    output logic [OUT_W-1:0]     m_tdata
);
    import spq_pkg::*;

    mode_t                 in_mode;
    logic [VW-1:0]         in_value;
    logic signed [PW-1:0]  in_pri;

    logic [VW-1:0]         val_reg  [DEPTH];
    logic signed [PW-1:0]  pri_reg  [DEPTH];
    logic [VW-1:0]         val_next [DEPTH];
    logic signed [PW-1:0]  pri_next [DEPTH];
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    mode_t                 mode_reg;
    logic [VW-1:0]         new_val_reg;
    logic signed [PW-1:0]  new_pri_reg;
    logic [DEPTH-1:0]      hit_reg;
    logic [DEPTH-1:0]      hit_next;
    logic [DEPTH-1:0]      thermo;
    logic [OUT_W-1:0]      out_reg;
    logic [OUT_W-1:0]      out_next;

    assign in_mode  = mode_t'(s_tdata[MODE_W-1:0]);
    assign in_value = s_tdata[MODE_W +: VW];
    assign in_pri   = $signed(s_tdata[MODE_W+VW +: PW]);

    // compare the new priority against the occupied cells and mark the slot; a push takes slot 0
    always_comb
    begin
        hit_next = '0;
        if (in_mode == MODE_PUSH || count_reg == '0 || in_pri <= pri_reg[0])
        begin
            hit_next[0] = 1'b1;
        end
        else
        begin
            for (int i = 1; i < DEPTH; i++)
            begin
                hit_next[i] = ((CW'(i) < count_reg) && (pri_reg[i] > in_pri))
                              || (CW'(i) == count_reg);
            end
        end
    end

    // thermometer: cells at or behind the insert slot
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            thermo[i] = |(hit_reg & ({DEPTH{1'b1}} >> (DEPTH - 1 - i)));
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            val_next[i] = val_reg[i];
            pri_next[i] = pri_reg[i];
        end
        count_next = count_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                count_next = count_reg + 1'b1;
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (i > 0 && thermo[(i > 0) ? i - 1 : 0])
                    begin
                        val_next[i] = val_reg[(i > 0) ? i - 1 : 0];
                        pri_next[i] = pri_reg[(i > 0) ? i - 1 : 0];
                    end
                    else if (thermo[i])
                    begin
                        val_next[i] = new_val_reg;
                        pri_next[i] = new_pri_reg;
                    end
                end
            end
            OP_REMOVE:
            begin
                count_next = count_reg - 1'b1;
                for (int i = 0; i < DEPTH - 1; i++)
                begin
                    val_next[i] = val_reg[i + 1];
                    pri_next[i] = pri_reg[i + 1];
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // pack the result: value, priority, empty, count, error from the low bit up
    always_comb
    begin
        out_next = '0;
        if (count_next != '0)
        begin
            out_next[0 +: VW]  = val_next[0];
            out_next[VW +: PW] = pri_next[0];
        end
        out_next[VW+PW]                 = (count_next == '0);
        out_next[VW+PW+1 +: CW]         = count_next;
        out_next[VW+PW+1+CW +: ERR_W]   = cmd.err;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            new_val_reg <= in_value;
            new_pri_reg <= in_pri;
            hit_reg     <= hit_next;
        end
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            val_reg[i] <= val_next[i];
            pri_reg[i] <= pri_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mode_reg  <= MODE_INSERT;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.capture)
            begin
                mode_reg <= in_mode;
            end
        end
    end

    assign status.ins_req = (mode_reg == MODE_INSERT) || (mode_reg == MODE_PUSH);
    assign status.rem_req = (mode_reg == MODE_REMOVE);
    assign status.full    = (count_reg == CW'(DEPTH));
    assign status.empty   = (count_reg == '0);
    assign m_tdata        = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("occupancy beyond queue depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_INSERT) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the queue");

endmodule
